FILE: sv/assert_macros.svh
// Assertion macros shared by the log ring RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: sv/oelr_pkg.sv
// Types and codes of the overwriting event log ring.
// No dependencies; used by the top level.
package oelr_pkg;

   // Request modes
   localparam logic [1:0] MODE_EMIT  = 2'd0;
   localparam logic [1:0] MODE_DRAIN = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Result kinds
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  event_type;
      logic [7:0]  outcome;
      logic        detail_present;
      logic [31:0] detail_word_0;
      logic [31:0] detail_word_1;
      logic [63:0] timestamp;
      logic [31:0] lifecycle_word;
      logic [4:0]  drain_max;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] seq;
      logic [63:0] event_time;
      logic [7:0]  record_type;
      logic [7:0]  record_outcome;
      logic [31:0] record_lifecycle;
      logic [31:0] record_detail_0;
      logic [31:0] record_detail_1;
      logic        last;
      logic [4:0]  unread_count;
      logic [31:0] emitted_total;
      logic [31:0] overflow_total;
   } rsp_word_type;

   // One stored log record as kept in the ring memory
   typedef struct packed {
      logic [31:0] seq;
      logic [63:0] event_time;
      logic [7:0]  event_type;
      logic [7:0]  outcome;
      logic [31:0] lifecycle;
      logic [31:0] detail_1;
      logic [31:0] detail_0;
   } record_type;

endpackage

FILE: sv/oelr_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
// No dependencies; the word type is set where the channel is declared.
interface oelr_stream_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: sv/overwriting_event_log_ring.sv
// Overwriting event log ring: records kept in one RAM, drained oldest first.
// Depends on oelr_pkg, oelr_stream_if, oelr_ram and assert_macros.svh.
//
//   channel  direction  word           handshake
//   req      in         req_word_type  valid/ready, taken when both high
//   rsp      out        rsp_word_type  valid/ready, taken when both high
//
// Emit, clear, unused modes and a drain that returns nothing load only a status word;
// one item per cycle while rsp is taken, the status word sitting in the output register.
// A drain of n > 0 records first issues a read to the RAM, then hands out one
// record per cycle out of the registered RAM port, then the status word.
// A stall on rsp holds the drain in place; req is taken only between items.
// Reset is synchronous and clears pointers and counters; the RAM is not cleared.
module overwriting_event_log_ring import oelr_pkg::*; #(
   parameter int DEPTH        = 16,
   parameter int DETAIL_WORDS = 2
) (
   input  logic          clock,
   input  logic          reset,
   oelr_stream_if.sink   req,
   oelr_stream_if.source rsp
);
`include "assert_macros.svh"

   localparam int PW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WAIT   = 3'b010,
      S_STATUS = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] count_ff, count_in;
   logic [FW-1:0] limit_ff, limit_in;
   logic [31:0]   seq_ff, seq_in;
   logic [31:0]   emit_ff, emit_in;
   logic [31:0]   ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   logic          ram_wr_en;
   logic          ram_rd_en;
   record_type    ram_wr_data;
   record_type    ram_rd_data;

   logic          slot_free;
   logic          req_fire;
   logic          load_status;
   logic          load_record;
   logic [FW-1:0] limit_w;
   logic [FW+4:0] fill_ext;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   // Record memory
   oelr_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Handshake
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.word  = rsp_word_ff;

   // Saturate the drain length to the ring depth
   assign limit_w = ({27'b0, req.word.drain_max} > 32'(DEPTH)) ? FW'(DEPTH)
                                                               : FW'(req.word.drain_max);

   // Build the record to store on emit
   always_comb begin
      ram_wr_data            = '0;
      ram_wr_data.seq        = seq_ff;
      ram_wr_data.event_time = req.word.timestamp;
      ram_wr_data.event_type = req.word.event_type;
      ram_wr_data.outcome    = req.word.outcome;
      ram_wr_data.lifecycle  = req.word.lifecycle_word;
      if (req.word.detail_present) begin
         ram_wr_data.detail_0 = req.word.detail_word_0;
         if (DETAIL_WORDS >= 2) begin
            ram_wr_data.detail_1 = req.word.detail_word_1;
         end
      end
   end

   // Sequence the operations
   always_comb begin
      state_in    = state_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      limit_in    = limit_ff;
      seq_in      = seq_ff;
      emit_in     = emit_ff;
      ovf_in      = ovf_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      load_status = 1'b0;
      load_record = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req.word.mode)
                  MODE_EMIT: begin
                     ram_wr_en = 1'b1;
                     seq_in    = seq_ff + 32'd1;
                     emit_in   = emit_ff + 32'd1;
                     wr_ptr_in = ring_next(wr_ptr_ff);
                     if (fill_ff != FW'(DEPTH)) begin
                        fill_in = fill_ff + FW'(1);
                     end else begin
                        // Overwrite the oldest record
                        rd_ptr_in = ring_next(rd_ptr_ff);
                        ovf_in    = ovf_ff + 32'd1;
                     end
                     load_status = 1'b1;
                  end
                  MODE_DRAIN: begin
                     if (limit_w != '0 && fill_ff != '0) begin
                        ram_rd_en = 1'b1;
                        rd_ptr_in = ring_next(rd_ptr_ff);
                        fill_in   = fill_ff - FW'(1);
                        count_in  = FW'(1);
                        limit_in  = limit_w;
                        state_in  = S_WAIT;
                     end else begin
                        load_status = 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     wr_ptr_in   = '0;
                     rd_ptr_in   = '0;
                     fill_in     = '0;
                     seq_in      = '0;
                     emit_in     = '0;
                     ovf_in      = '0;
                     load_status = 1'b1;
                  end
                  default: begin
                     load_status = 1'b1;
                  end
               endcase
            end
         end
         S_WAIT: begin
            // Hand the read record out and fetch the next one behind it
            if (slot_free) begin
               load_record = 1'b1;
               if (count_ff != limit_ff && fill_ff != '0) begin
                  ram_rd_en = 1'b1;
                  rd_ptr_in = ring_next(rd_ptr_ff);
                  fill_in   = fill_ff - FW'(1);
                  count_in  = count_ff + FW'(1);
               end else begin
                  state_in = S_STATUS;
               end
            end
         end
         S_STATUS: begin
            if (slot_free) begin
               load_status = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load status or record, drop a taken word
   assign fill_ext = {5'b0, fill_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in  = rsp_word_ff;
      if (load_status) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in                = '0;
         rsp_word_in.kind           = KIND_STATUS;
         rsp_word_in.last           = 1'b1;
         rsp_word_in.unread_count   = fill_ext[4:0];
         rsp_word_in.emitted_total  = emit_in;
         rsp_word_in.overflow_total = ovf_in;
      end else if (load_record) begin
         rsp_valid_in                 = 1'b1;
         rsp_word_in                  = '0;
         rsp_word_in.kind             = KIND_RECORD;
         rsp_word_in.seq              = ram_rd_data.seq;
         rsp_word_in.event_time       = ram_rd_data.event_time;
         rsp_word_in.record_type      = ram_rd_data.event_type;
         rsp_word_in.record_outcome   = ram_rd_data.outcome;
         rsp_word_in.record_lifecycle = ram_rd_data.lifecycle;
         rsp_word_in.record_detail_0  = ram_rd_data.detail_0;
         rsp_word_in.record_detail_1  = ram_rd_data.detail_1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= '0;
         seq_ff       <= '0;
         emit_ff      <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         seq_ff       <= seq_in;
         emit_ff      <= emit_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // Checks
   `ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(DEPTH),
      "fill count above ring depth")
   `ASSERT_IMPLY(a_drain_count, clock, reset, state_ff == S_WAIT,
      count_ff != '0 && count_ff <= limit_ff, "drain count outside its limit")
   `ASSERT_NEXT(a_overwrite, clock, reset,
      req_fire && req.word.mode == MODE_EMIT && fill_ff == FW'(DEPTH),
      ovf_ff == $past(ovf_ff) + 32'd1 && fill_ff == $past(fill_ff),
      "emit into full ring did not count an overflow")
endmodule

FILE: sv/oelr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module oelr_ram #(
   parameter int WIDTH = 208,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last word read until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
